// ===== rtl/ofl_pkg.sv =====
// Shared types and codes for the ordered fingerprint log checker.
// No dependencies.
`default_nettype none
package ofl_pkg;

    localparam int LOG_DEPTH_DEF   = 1024;
    localparam int DIGEST_BITS_DEF = 64;
    localparam int MAX_RANGE_DEF   = 16;
    localparam int CAP_W           = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ACT_APPEND  = 3'd0,
        ACT_LOOKUP  = 3'd1,
        ACT_LASTGEN = 3'd2,
        ACT_REPLACE = 3'd3,
        ACT_RANGE   = 3'd4,
        ACT_CLEAR   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DIGEST   = 3'd1,
        ST_IDENTITY = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADRANGE = 3'd4,
        ST_MISSING  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SRCH,
        S_SCMP,
        S_POST,
        S_PCHK,
        S_R1,
        S_R2,
        S_CCHK,
        S_CWR
    } state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [31:0] hit_generation;
        logic [31:0] hit_frame;
        logic [63:0] hit_digest;
        logic [31:0] end_generation;
        logic [31:0] end_frame;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/ofl_store.sv =====
// Coordinate and digest memories of the log, one read and one write port.
// Depends on nothing but its parameters.
`default_nettype none
module ofl_store #(
    parameter int LOG_DEPTH   = 1024,
    parameter int DIGEST_BITS = 64
) (
    input  wire                          clk,
    input  wire [$clog2(LOG_DEPTH)-1:0]  rd_addr,
    output logic [63:0]                  rd_coord,
    output logic [DIGEST_BITS-1:0]       rd_dig,
    input  wire [$clog2(LOG_DEPTH)-1:0]  wr_addr,
    input  wire                          coord_we,
    input  wire [63:0]                   wr_coord,
    input  wire                          dig_we,
    input  wire [DIGEST_BITS-1:0]        wr_dig
);

    logic [63:0]            coord_mem [LOG_DEPTH];
    logic [DIGEST_BITS-1:0] dig_mem   [LOG_DEPTH];

    always_ff @(posedge clk)
    begin
        if (coord_we)
        begin
            coord_mem[wr_addr] <= wr_coord;
        end
        rd_coord <= coord_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            dig_mem[wr_addr] <= wr_dig;
        end
        rd_dig <= dig_mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/ordered_fingerprint_log_checker_unit.sv =====
// Ordered fingerprint log checker: sequencer, shared compare unit, range buffer.
// Depends on ofl_pkg and ofl_store.
// Append, lookup and last-in-generation run a binary search over the n held entries.
// Replace commit of m elements searches, then checks and writes each; range and clear do not search.
// One request at a time: busy stays high until the request ends; the receiver cannot stall.
// Reset clears entry count and range buffer, sets capacity to 1024; memories need no clearing.
`default_nettype none
module ordered_fingerprint_log_checker_unit
    import ofl_pkg::*;
#(
    parameter int LOG_DEPTH   = LOG_DEPTH_DEF,
    parameter int DIGEST_BITS = DIGEST_BITS_DEF,
    parameter int MAX_RANGE   = MAX_RANGE_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  action,
    input  wire  [31:0] generation,
    input  wire  [31:0] frame,
    input  wire  [63:0] digest,
    input  wire  [31:0] new_generation,
    input  wire  [31:0] new_frame,
    input  wire  [63:0] new_digest,
    input  wire         range_end,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [10:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic        found,
    output logic [31:0] hit_generation,
    output logic [31:0] hit_frame,
    output logic [63:0] hit_digest,
    output logic [31:0] end_generation,
    output logic [31:0] end_frame
);

    localparam int AW  = $clog2(LOG_DEPTH);
    localparam int CW  = $clog2(LOG_DEPTH + 1);
    localparam int PW  = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1;
    localparam int PLW = $clog2(MAX_RANGE + 1);
    localparam int SW  = ((CW > PLW) ? CW : PLW) + 1;
    localparam int LW  = (CW > CAP_W) ? CW : CAP_W;

    state_t                 state_reg, state_next;
    logic [2:0]             act_reg, act_next;
    logic [63:0]            key_reg, key_next;
    logic [DIGEST_BITS-1:0] dig_reg, dig_next;
    logic [CW-1:0]          lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   strict_reg, strict_next;
    logic [PLW-1:0]         ci_reg, ci_next;
    logic [PLW-1:0]         plen_reg, plen_next;
    logic                   povf_reg, povf_next;
    logic [CAP_W-1:0]       cap_reg;
    res_t                   res_reg, res_next;
    logic                   done_reg, done_next;

    // replacement fields held with the request
    logic [63:0]            new_digest_reg;
    logic                   ndiff_reg;
    logic                   last_reg;

    logic [63:0]            pcoord [MAX_RANGE];
    logic [DIGEST_BITS-1:0] pdig   [MAX_RANGE];
    logic [DIGEST_BITS-1:0] prep   [MAX_RANGE];
    logic                   pdiff  [MAX_RANGE];
    logic                   pend_we;

    logic [AW-1:0]          rd_addr, wr_addr;
    logic [63:0]            rd_coord, wr_coord;
    logic [DIGEST_BITS-1:0] rd_dig, wr_dig;
    logic                   coord_we, dig_we;

    ofl_store #(
        .LOG_DEPTH   (LOG_DEPTH),
        .DIGEST_BITS (DIGEST_BITS)
    ) u_store (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_coord (rd_coord),
        .rd_dig   (rd_dig),
        .wr_addr  (wr_addr),
        .coord_we (coord_we),
        .wr_coord (wr_coord),
        .dig_we   (dig_we),
        .wr_dig   (wr_dig)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done           = done_reg;
    assign status         = res_reg.status;
    assign found          = res_reg.found;
    assign hit_generation = res_reg.hit_generation;
    assign hit_frame      = res_reg.hit_frame;
    assign hit_digest     = res_reg.hit_digest;
    assign end_generation = res_reg.end_generation;
    assign end_frame      = res_reg.end_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            plen_reg  <= '0;
            povf_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            plen_reg  <= plen_next;
            povf_reg  <= povf_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        dig_reg    <= dig_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        strict_reg <= strict_next;
        ci_reg     <= ci_next;
        res_reg    <= res_next;
        if (pend_we)
        begin
            pcoord[plen_reg[PW-1:0]] <= key_reg;
            pdig[plen_reg[PW-1:0]]   <= dig_reg;
            prep[plen_reg[PW-1:0]]   <= new_digest_reg[DIGEST_BITS-1:0];
            pdiff[plen_reg[PW-1:0]]  <= ndiff_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            new_digest_reg <= new_digest;
            ndiff_reg      <= ({new_generation, new_frame} != {generation, frame});
            last_reg       <= range_end;
        end
    end

    always_comb
    begin : seq
        logic [CW-1:0] mid;
        logic          below;
        logic          full;
        logic [SW-1:0] addr_sum;
        logic [PW-1:0] ci;

        state_next  = state_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        dig_next    = dig_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        strict_next = strict_reg;
        ci_next     = ci_reg;
        cnt_next    = cnt_reg;
        plen_next   = plen_reg;
        povf_next   = povf_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        pend_we     = 1'b0;
        rd_addr     = mid_reg[AW-1:0];
        wr_addr     = cnt_reg[AW-1:0];
        wr_coord    = key_reg;
        wr_dig      = dig_reg;
        coord_we    = 1'b0;
        dig_we      = 1'b0;

        mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
        below    = strict_reg ? (rd_coord <= key_reg) : (rd_coord < key_reg);
        full     = (LW'(cnt_reg) >= LW'(cap_reg)) || (LW'(cnt_reg) >= LW'(LOG_DEPTH));
        ci       = ci_reg[PW-1:0];
        addr_sum = SW'(lo_reg) + SW'(ci_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    key_next   = {generation, frame};
                    dig_next   = digest[DIGEST_BITS-1:0];
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                lo_next     = '0;
                hi_next     = cnt_reg;
                strict_next = 1'b0;
                state_next  = S_SRCH;
                priority case (act_reg)
                    ACT_APPEND, ACT_LOOKUP:
                    begin
                    end
                    ACT_LASTGEN:
                    begin
                        strict_next = 1'b1;
                        key_next    = {key_reg[63:32], 32'hFFFF_FFFF};
                        if (key_reg[63:32] == 32'd0 || cnt_reg == '0)
                        begin
                            res_next   = '{status: ST_MISSING, default: '0};
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    ACT_REPLACE:
                    begin
                        if (PLW'(plen_reg) < PLW'(MAX_RANGE))
                        begin
                            pend_we   = 1'b1;
                            plen_next = plen_reg + 1'b1;
                        end
                        else
                        begin
                            povf_next = 1'b1;
                        end
                        if (!last_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (PLW'(plen_reg) >= PLW'(MAX_RANGE) || povf_reg)
                        begin
                            res_next   = '{status: ST_BADRANGE, default: '0};
                            done_next  = 1'b1;
                            plen_next  = '0;
                            povf_next  = 1'b0;
                            state_next = S_IDLE;
                        end
                        else if (plen_reg != '0)
                        begin
                            key_next = pcoord[0];
                        end
                    end
                    ACT_RANGE:
                    begin
                        rd_addr = '0;
                        if (cnt_reg == '0)
                        begin
                            res_next   = '{status: ST_MISSING, default: '0};
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_R1;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        cnt_next   = '0;
                        res_next   = '{status: ST_OK, default: '0};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    rd_addr    = mid[AW-1:0];
                    state_next = S_SCMP;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_SCMP:
            begin
                if (below)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_POST:
            begin
                rd_addr    = lo_reg[AW-1:0];
                state_next = S_PCHK;
                priority case (act_reg)
                    ACT_APPEND:
                    begin
                        if (lo_reg >= cnt_reg)
                        begin
                            if (full)
                            begin
                                res_next = '{status: ST_FULL, default: '0};
                            end
                            else
                            begin
                                coord_we = 1'b1;
                                dig_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                res_next = '{status: ST_OK, default: '0};
                            end
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        if (lo_reg >= cnt_reg)
                        begin
                            res_next   = '{status: ST_MISSING, default: '0};
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    ACT_LASTGEN:
                    begin
                        rd_addr = AW'(lo_reg - 1'b1);
                        if (lo_reg == '0)
                        begin
                            res_next   = '{status: ST_MISSING, default: '0};
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        ci_next = '0;
                        if (SW'(lo_reg) + SW'(plen_reg) > SW'(cnt_reg))
                        begin
                            res_next   = '{status: ST_MISSING, default: '0};
                            done_next  = 1'b1;
                            plen_next  = '0;
                            povf_next  = 1'b0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_CCHK;
                        end
                    end
                endcase
            end
            S_PCHK:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                res_next   = '{status: ST_MISSING, default: '0};
                priority case (act_reg)
                    ACT_APPEND:
                    begin
                        if (rd_coord == key_reg)
                        begin
                            res_next.status = (rd_dig == dig_reg) ? ST_OK : ST_DIGEST;
                        end
                        else
                        begin
                            res_next.status = ST_IDENTITY;
                        end
                    end
                    default:
                    begin
                        if ((act_reg == ACT_LOOKUP && rd_coord == key_reg) ||
                            (act_reg != ACT_LOOKUP && rd_coord[63:32] == key_reg[63:32]))
                        begin
                            res_next = '{status: ST_OK, found: 1'b1,
                                         hit_generation: rd_coord[63:32],
                                         hit_frame: rd_coord[31:0],
                                         hit_digest: 64'(rd_dig), default: '0};
                        end
                    end
                endcase
            end
            S_R1:
            begin
                rd_addr    = AW'(cnt_reg - 1'b1);
                res_next   = '{status: ST_OK, found: 1'b1,
                               hit_generation: rd_coord[63:32],
                               hit_frame: rd_coord[31:0], default: '0};
                state_next = S_R2;
            end
            S_R2:
            begin
                res_next.end_generation = rd_coord[63:32];
                res_next.end_frame      = rd_coord[31:0];
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            S_CCHK:
            begin
                rd_addr = addr_sum[AW-1:0];
                if (ci_reg != '0)
                begin
                    if (rd_coord != pcoord[ci - 1'b1] || pdiff[ci - 1'b1])
                    begin
                        res_next   = '{status: ST_IDENTITY, default: '0};
                        done_next  = 1'b1;
                        plen_next  = '0;
                        povf_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (rd_dig != pdig[ci - 1'b1])
                    begin
                        res_next   = '{status: ST_DIGEST, default: '0};
                        done_next  = 1'b1;
                        plen_next  = '0;
                        povf_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (ci_reg == plen_reg)
                    begin
                        ci_next    = '0;
                        state_next = S_CWR;
                    end
                    else
                    begin
                        ci_next = ci_reg + 1'b1;
                    end
                end
                else
                begin
                    ci_next = ci_reg + 1'b1;
                end
            end
            S_CWR:
            begin
                wr_addr = addr_sum[AW-1:0];
                wr_dig  = prep[ci];
                dig_we  = 1'b1;
                ci_next = ci_reg + 1'b1;
                if (ci_reg + 1'b1 == plen_reg)
                begin
                    res_next   = '{status: ST_OK, default: '0};
                    done_next  = 1'b1;
                    plen_next  = '0;
                    povf_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // note: in S_CCHK the read issued at step i is checked at step i+1

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(cnt_reg) <= LW'(LOG_DEPTH))
        else $error("entry count beyond depth");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(plen_reg) <= SW'(MAX_RANGE))
        else $error("range buffer overrun");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result given while busy");

endmodule
`default_nettype wire

// ===== sim/tb_ordered_fingerprint_log_checker_unit.sv =====
// Self-checking testbench for ordered_fingerprint_log_checker_unit: directed,
// capacity and random requests, predicted in the bench and checked in order on each done strobe.
// Depends on ofl_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_ordered_fingerprint_log_checker_unit
    import ofl_pkg::*;
();

    localparam int DEPTH = 1024;
    localparam int RANGE_MAX = 16;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    typedef struct {
        logic [2:0]  act;
        logic [31:0] gen;
        logic [31:0] frm;
        logic [63:0] dig;
        logic [31:0] ngen;
        logic [31:0] nfrm;
        logic [63:0] ndig;
        logic        last;
    } req_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  action;
    logic [31:0] generation;
    logic [31:0] frame;
    logic [63:0] digest;
    logic [31:0] new_generation;
    logic [31:0] new_frame;
    logic [63:0] new_digest;
    logic        range_end;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;
    logic        done;
    logic [2:0]  status;
    logic        found;
    logic [31:0] hit_generation;
    logic [31:0] hit_frame;
    logic [63:0] hit_digest;
    logic [31:0] end_generation;
    logic [31:0] end_frame;

    ordered_fingerprint_log_checker_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .generation(generation), .frame(frame), .digest(digest),
        .new_generation(new_generation), .new_frame(new_frame), .new_digest(new_digest),
        .range_end(range_end), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .done(done), .status(status), .found(found),
        .hit_generation(hit_generation), .hit_frame(hit_frame), .hit_digest(hit_digest),
        .end_generation(end_generation), .end_frame(end_frame)
    );

    // predictor state
    logic [63:0] log_coord [DEPTH];
    logic [63:0] log_digest [DEPTH];
    int unsigned log_count;
    int unsigned cap_limit;
    logic [63:0] buf_coord [RANGE_MAX];
    logic [63:0] buf_digest [RANGE_MAX];
    logic [63:0] buf_repl [RANGE_MAX];
    bit          buf_differs [RANGE_MAX];
    int unsigned buf_len;
    bit          buf_overflow;

    res_t        expected_results[$];
    int          errors;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned find_pos(input logic [63:0] key, input bit strict);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = log_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (strict ? (log_coord[mid] <= key) : (log_coord[mid] < key))
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic status_t commit_status();
        int unsigned first;
        if (buf_len == 0)
            return ST_BADRANGE;
        first = find_pos(buf_coord[0], 1'b0);
        if (first + buf_len > log_count)
            return ST_MISSING;
        for (int i = 0; i < buf_len; i++) begin
            if (log_coord[first + i] != buf_coord[i] || buf_differs[i])
                return ST_IDENTITY;
            if (log_digest[first + i] != buf_digest[i])
                return ST_DIGEST;
        end
        for (int i = 0; i < buf_len; i++)
            log_digest[first + i] = buf_repl[i];
        return ST_OK;
    endfunction

    function automatic bit predict_result(input req_t q, output res_t r);
        logic [63:0] key;
        int unsigned pos;
        int unsigned lim;
        int unsigned after;
        key = {q.gen, q.frm};
        r = '0;
        case (q.act)
            ACT_APPEND:
            begin
                pos = find_pos(key, 1'b0);
                lim = (cap_limit < DEPTH) ? cap_limit : DEPTH;
                if (pos < log_count && log_coord[pos] == key)
                    r.status = (log_digest[pos] == q.dig) ? ST_OK : ST_DIGEST;
                else if (pos < log_count)
                    r.status = ST_IDENTITY;
                else if (log_count >= lim)
                    r.status = ST_FULL;
                else begin
                    log_coord[log_count] = key;
                    log_digest[log_count] = q.dig;
                    log_count++;
                end
            end
            ACT_LOOKUP, ACT_LASTGEN:
            begin
                if (q.act == ACT_LOOKUP) begin
                    pos = find_pos(key, 1'b0);
                    if (pos >= log_count || log_coord[pos] != key)
                        pos = log_count;
                end
                else begin
                    pos = log_count;
                    if (q.gen != 0 && log_count != 0) begin
                        after = find_pos({q.gen, 32'hFFFF_FFFF}, 1'b1);
                        if (after != 0 && log_coord[after - 1][63:32] == q.gen)
                            pos = after - 1;
                    end
                end
                if (pos < log_count) begin
                    r.found = 1'b1;
                    r.hit_generation = log_coord[pos][63:32];
                    r.hit_frame = log_coord[pos][31:0];
                    r.hit_digest = log_digest[pos];
                end
                else
                    r.status = ST_MISSING;
            end
            ACT_REPLACE:
            begin
                if (buf_len < RANGE_MAX) begin
                    buf_coord[buf_len] = key;
                    buf_digest[buf_len] = q.dig;
                    buf_repl[buf_len] = q.ndig;
                    buf_differs[buf_len] = ({q.ngen, q.nfrm} != key);
                    buf_len++;
                end
                else
                    buf_overflow = 1'b1;
                if (!q.last)
                    return 1'b0;
                r.status = buf_overflow ? ST_BADRANGE : commit_status();
                buf_len = 0;
                buf_overflow = 1'b0;
            end
            ACT_RANGE:
            begin
                if (log_count == 0)
                    r.status = ST_MISSING;
                else begin
                    r.found = 1'b1;
                    r.hit_generation = log_coord[0][63:32];
                    r.hit_frame = log_coord[0][31:0];
                    r.end_generation = log_coord[log_count - 1][63:32];
                    r.end_frame = log_coord[log_count - 1][31:0];
                end
            end
            ACT_CLEAR:
                log_count = 0;
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && done) begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", {61'd0, status}, 64'd0);
            else begin
                w = expected_results.pop_front();
                if (status !== w.status)
                    report_mismatch("status", {61'd0, status}, {61'd0, w.status});
                if (found !== w.found)
                    report_mismatch("found", {63'd0, found}, {63'd0, w.found});
                if (hit_generation !== w.hit_generation)
                    report_mismatch("hit_generation", {32'd0, hit_generation},
                                    {32'd0, w.hit_generation});
                if (hit_frame !== w.hit_frame)
                    report_mismatch("hit_frame", {32'd0, hit_frame}, {32'd0, w.hit_frame});
                if (hit_digest !== w.hit_digest)
                    report_mismatch("hit_digest", hit_digest, w.hit_digest);
                if (end_generation !== w.end_generation)
                    report_mismatch("end_generation", {32'd0, end_generation},
                                    {32'd0, w.end_generation});
                if (end_frame !== w.end_frame)
                    report_mismatch("end_frame", {32'd0, end_frame}, {32'd0, w.end_frame});
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_req(input req_t q);
        res_t r;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action <= q.act;
        generation <= q.gen;
        frame <= q.frm;
        digest <= q.dig;
        new_generation <= q.ngen;
        new_frame <= q.nfrm;
        new_digest <= q.ndig;
        range_end <= q.last;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (predict_result(q, r))
            expected_results.insert(expected_results.size(), r);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [10:0] value);
        drain();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_limit = value;
    endtask

    function automatic req_t make_req(input logic [2:0] act, input logic [63:0] key,
                                      input logic [63:0] dig);
        req_t q;
        q.act = act;
        q.gen = key[63:32];
        q.frm = key[31:0];
        q.dig = dig;
        q.ngen = key[63:32];
        q.nfrm = key[31:0];
        q.ndig = {$urandom, $urandom};
        q.last = 1'b1;
        return q;
    endfunction

    function automatic logic [63:0] next_key();
        logic [63:0] top;
        int p;
        top = (log_count == 0) ? {32'd0, $urandom_range(0, 3)} : log_coord[log_count - 1];
        p = $urandom_range(0, 99);
        if (p < 55)
            return top + $urandom_range(1, 5);
        else if (p < 85)
            return {top[63:32] + 32'd1, $urandom};
        else if (p < 95)
            return {$urandom, $urandom};
        return top - $urandom_range(0, 3);
    endfunction

    // streams a replace range over held entries; may be corrupted, overlong or past the end
    task automatic send_range();
        req_t q;
        int unsigned first;
        int unsigned len;
        int bad;
        int p;
        first = (log_count == 0) ? 0 : $urandom_range(0, log_count - 1);
        len = (log_count > first) ? $urandom_range(1, log_count - first) : 1;
        if (len > RANGE_MAX)
            len = $urandom_range(1, RANGE_MAX);
        p = $urandom_range(0, 99);
        if (p < 5)
            len = RANGE_MAX + $urandom_range(1, 3);
        else if (p < 10)
            len = len + $urandom_range(1, 3);
        bad = ($urandom_range(0, 99) < 25) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (first + i < log_count)
                q = make_req(ACT_REPLACE, log_coord[first + i], log_digest[first + i]);
            else
                q = make_req(ACT_REPLACE, {$urandom, $urandom}, {$urandom, $urandom});
            q.last = (i == len - 1);
            if (i == bad) begin
                case ($urandom_range(0, 4))
                    0: q.dig[$urandom_range(0, 63)] ^= 1'b1;
                    1: q.frm[$urandom_range(0, 31)] ^= 1'b1;
                    2: q.ngen[$urandom_range(0, 31)] ^= 1'b1;
                    3: q.nfrm[$urandom_range(0, 31)] ^= 1'b1;
                    default: q.gen = $urandom;
                endcase
            end
            send_req(q);
        end
    endtask

    task automatic random_req();
        req_t q;
        int p;
        int unsigned idx;
        p = $urandom_range(0, 99);
        idx = (log_count == 0) ? 0 : $urandom_range(0, log_count - 1);
        if (p < 40)
            q = make_req(ACT_APPEND, next_key(), {$urandom, $urandom});
        else if (p < 48 && log_count != 0)
            q = make_req(ACT_APPEND, log_coord[idx],
                         $urandom_range(0, 1) ? log_digest[idx] : {$urandom, $urandom});
        else if (p < 60)
            q = make_req(ACT_LOOKUP, (log_count != 0 && p < 56) ? log_coord[idx]
                         : {$urandom, $urandom}, {$urandom, $urandom});
        else if (p < 70)
            q = make_req(ACT_LASTGEN, (log_count != 0 && p < 67)
                         ? {log_coord[idx][63:32], $urandom}
                         : {($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, $urandom},
                         {$urandom, $urandom});
        else if (p < 75)
            q = make_req(ACT_RANGE, {$urandom, $urandom}, {$urandom, $urandom});
        else if (p < 77)
            q = make_req(ACT_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
        else if (p < 78)
            q = make_req($urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B,
                         {$urandom, $urandom}, {$urandom, $urandom});
        else begin
            send_range();
            return;
        end
        q.ngen = $urandom;
        q.nfrm = $urandom;
        q.last = $urandom_range(0, 1);
        send_req(q);
    endtask

    task automatic test_directed();
        req_t q;
        send_req(make_req(ACT_RANGE, 64'd0, 64'd0));
        send_req(make_req(ACT_LOOKUP, 64'd0, 64'd0));
        send_req(make_req(ACT_LASTGEN, 64'd0, 64'd0));
        send_req(make_req(ACT_APPEND, 64'd0, 64'd0));
        send_req(make_req(ACT_APPEND, {32'd5, 32'd7}, 64'hFFFF_FFFF_FFFF_FFFF));
        send_req(make_req(ACT_APPEND, {32'd5, 32'd9}, 64'h0123_4567_89AB_CDEF));
        send_req(make_req(ACT_APPEND, {32'd5, 32'd7}, 64'hFFFF_FFFF_FFFF_FFFF));
        send_req(make_req(ACT_APPEND, {32'd5, 32'd7}, 64'd1));
        send_req(make_req(ACT_APPEND, {32'd5, 32'd8}, 64'd1));
        send_req(make_req(ACT_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3));
        send_req(make_req(ACT_LOOKUP, {32'd5, 32'd9}, 64'd0));
        send_req(make_req(ACT_LOOKUP, {32'd5, 32'd8}, 64'd0));
        send_req(make_req(ACT_LASTGEN, {32'd5, 32'd0}, 64'd0));
        send_req(make_req(ACT_LASTGEN, {32'd6, 32'd0}, 64'd0));
        send_req(make_req(ACT_LASTGEN, {32'd0, 32'hFFFF_FFFF}, 64'd0));
        send_req(make_req(ACT_RANGE, 64'd0, 64'd0));
        q = make_req(ACT_REPLACE, {32'd5, 32'd7}, 64'hFFFF_FFFF_FFFF_FFFF);
        q.last = 1'b0;
        send_req(q);
        send_req(make_req(ACT_REPLACE, {32'd5, 32'd9}, 64'h0123_4567_89AB_CDEF));
        q = make_req(ACT_REPLACE, {32'd5, 32'd9}, 64'd0);
        q.ndig = 64'd0;
        send_req(q);
        q = make_req(ACT_REPLACE, {32'd5, 32'd9}, log_digest[2]);
        q.nfrm = 32'd10;
        send_req(q);
        send_req(make_req(ACT_REPLACE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3));
        q = make_req(ACT_REPLACE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
        q.last = 1'b0;
        send_req(q);
        send_req(make_req(ACT_REPLACE, {32'd9, 32'd9}, 64'd3));
        for (int i = 0; i <= RANGE_MAX; i++) begin
            q = make_req(ACT_REPLACE, {32'd5, 32'd7}, 64'hFFFF_FFFF_FFFF_FFFF);
            q.last = (i == RANGE_MAX);
            send_req(q);
        end
        q = make_req(ACT_REPLACE, 64'd0, 64'd0);
        q.last = 1'b0;
        send_req(q);
        send_req(make_req(ACT_CLEAR, 64'd0, 64'd0));
        send_req(make_req(ACT_SPARE_A, 64'd0, 64'd0));
        send_req(make_req(ACT_SPARE_B, 64'd0, 64'd0));
        send_req(make_req(ACT_REPLACE, {32'd5, 32'd7}, 64'd0));
        send_req(make_req(ACT_RANGE, 64'd0, 64'd0));
    endtask

    task automatic test_capacity();
        write_capacity(11'd0);
        send_req(make_req(ACT_APPEND, 64'd1, 64'd1));
        write_capacity(11'd2047);
        for (int i = 0; i < DEPTH + 2; i++)
            send_req(make_req(ACT_APPEND, {32'(i / 8), 32'(i * 3)}, {$urandom, $urandom}));
        for (int i = 0; i < 20; i++)
            send_req(make_req(ACT_LOOKUP, log_coord[$urandom_range(0, DEPTH - 1)], 64'd0));
        send_req(make_req(ACT_RANGE, 64'd0, 64'd0));
        send_req(make_req(ACT_CLEAR, 64'd0, 64'd0));
        write_capacity(11'd3);
        for (int i = 0; i < 5; i++)
            send_req(make_req(ACT_APPEND, {32'd1, 32'(i)}, 64'd7));
    endtask

    task automatic test_random();
        logic [10:0] limits [4];
        limits[0] = 11'd1024;
        limits[1] = 11'd12;
        limits[2] = 11'd1;
        limits[3] = 11'($urandom_range(0, 2047));
        for (int ph = 0; ph < 4; ph++) begin
            write_capacity(limits[ph]);
            for (int i = 0; i < 45; i++) begin
                if (ph == 1 && i == 22)
                    drain();
                if (log_count > 60 && $urandom_range(0, 9) == 0)
                    send_req(make_req(ACT_CLEAR, 64'd0, 64'd0));
                random_req();
            end
        end
    endtask

    initial
    begin
        errors = 0;
        log_count = 0;
        cap_limit = CAP_RESET;
        buf_len = 0;
        buf_overflow = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_APPEND;
        generation = '0;
        frame = '0;
        digest = '0;
        new_generation = '0;
        new_frame = '0;
        new_digest = '0;
        range_end = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_random();
        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("FAIL");
        $finish;
    end

endmodule
